@@ rtl/alc_pkg.sv @@
`default_nettype none

package alc_pkg;

    // Columns scanned by one pipeline stage
    localparam int COLS_PER_STAGE = 8;

    localparam int EXP_W = 6;
    localparam int CFG_W = 6;
    localparam int MASK_W = 32;

    localparam logic [EXP_W-1:0] EXP_MAX = 6'd63;
    localparam logic [CFG_W-1:0] WORD_BITS_RESET = 6'd32;

    // Column codes {sum, second, first}
    localparam logic [2:0] COL_EMPTY = 3'd0;
    localparam logic [2:0] COL_FULL  = 3'd7;

    typedef struct packed {
        logic             carry;
        logic             zero;
        logic             neg;
        logic [EXP_W-1:0] exponent;
    } scan_state_t;

    localparam scan_state_t SCAN_INIT = '{carry: 1'b0, zero: 1'b0, neg: 1'b0,
                                          exponent: '0};

    // One column of the scan, most significant column first
    function automatic scan_state_t col_step(input scan_state_t st, input logic fa,
                                             input logic fb, input logic fs);
        scan_state_t nx;
        logic [2:0]  col;
        nx  = st;
        col = {fs, fb, fa};
        nx.neg = st.neg ^ ((fa ^ fs) & (fb ^ fs));
        if (!st.zero) begin
            if (st.carry) begin
                if (st.exponent != EXP_MAX) begin
                    nx.exponent = st.exponent + 1'b1;
                end
                // odd column weight clears the carry, even keeps it
                nx.carry = ~(fa ^ fb ^ fs);
            end else if (col == COL_FULL) begin
                nx.carry = 1'b1;
            end else if (col != COL_EMPTY) begin
                nx.zero = 1'b1;
            end
        end
        return nx;
    endfunction

endpackage

`default_nettype wire

@@ rtl/alc_in_if.sv @@
`default_nettype none

interface alc_in_if;
    logic                           valid;
    logic                           ready;
    logic [alc_pkg::MASK_W-1:0]     mask_first;
    logic [alc_pkg::MASK_W-1:0]     mask_second;
    logic [alc_pkg::MASK_W-1:0]     mask_sum;

    modport source (output valid, output mask_first, output mask_second,
                    output mask_sum, input ready);
    modport sink   (input valid, input mask_first, input mask_second,
                    input mask_sum, output ready);
endinterface

`default_nettype wire

@@ rtl/alc_out_if.sv @@
`default_nettype none

interface alc_out_if;
    logic                           valid;
    logic                           ready;
    logic                           corr_zero;
    logic [alc_pkg::EXP_W-1:0]      corr_exponent;
    logic                           corr_negative;

    modport source (output valid, output corr_zero, output corr_exponent,
                    output corr_negative, input ready);
    modport sink   (input valid, input corr_zero, input corr_exponent,
                    input corr_negative, output ready);
endinterface

`default_nettype wire

@@ rtl/alc_scan_stage.sv @@
`default_nettype none

module alc_scan_stage #(
    parameter int PAD_W     = 32,
    parameter int STAGE_IDX = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PAD_W-1:0]      in_first,
    input  wire logic [PAD_W-1:0]      in_second,
    input  wire logic [PAD_W-1:0]      in_sum,
    input  wire alc_pkg::scan_state_t  in_state,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [PAD_W-1:0]           out_first,
    output logic [PAD_W-1:0]           out_second,
    output logic [PAD_W-1:0]           out_sum,
    output alc_pkg::scan_state_t       out_state
);

    localparam int HI = PAD_W - 1 - STAGE_IDX * alc_pkg::COLS_PER_STAGE;

    logic                 valid_reg;
    logic [PAD_W-1:0]     first_reg;
    logic [PAD_W-1:0]     second_reg;
    logic [PAD_W-1:0]     sum_reg;
    alc_pkg::scan_state_t state_reg;
    alc_pkg::scan_state_t state_next;

    // Advance through this stage's columns, top one first
    always_comb
    begin
        state_next = in_state;
        for (int j = 0; j < alc_pkg::COLS_PER_STAGE; j++)
        begin
            state_next = alc_pkg::col_step(state_next, in_first[HI-j],
                                           in_second[HI-j], in_sum[HI-j]);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            first_reg  <= in_first;
            second_reg <= in_second;
            sum_reg    <= in_sum;
            state_reg  <= state_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_first  = first_reg;
    assign out_second = second_reg;
    assign out_sum    = sum_reg;
    assign out_state  = state_reg;

endmodule

`default_nettype wire

@@ rtl/add_linear_correlation_core.sv @@
`default_nettype none

// Linear correlation of modular addition. Each beat on mask_in carries a mask
// triple (first addend, second addend, sum); the matching beat on corr_out gives
// the correlation as a zero flag, an exponent and a sign, so that a non-zero
// correlation equals (-1)^corr_negative * 2^-corr_exponent. Only the low
// word_bits mask bits take part (values above WORD_BITS count as WORD_BITS,
// zero means no bits and gives correlation +1). One triple is taken per clock
// while nothing stalls; each passes through one input register, one scan stage
// for every eight bit columns, and the output register. A stall on corr_out
// backs up through the stage registers and holds mask_in ready low only once
// every stage is full. Write word_bits only while no beat is in flight.
module add_linear_correlation_core #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        word_bits_we,
    input  wire logic [alc_pkg::CFG_W-1:0]   word_bits_wdata,
    alc_in_if.sink                           mask_in,
    alc_out_if.source                        corr_out
);

    // Number of eight-column scan stages and the padded scan width. Padding
    // sits above the top bit: empty columns with a clear carry change nothing.
    localparam int NSTG  = (WORD_BITS + alc_pkg::COLS_PER_STAGE - 1) /
                           alc_pkg::COLS_PER_STAGE;
    localparam int PAD_W = NSTG * alc_pkg::COLS_PER_STAGE;
    localparam int LIM_A = (WORD_BITS < alc_pkg::MASK_W) ? WORD_BITS : alc_pkg::MASK_W;
    localparam int LIM   = (LIM_A < PAD_W) ? LIM_A : PAD_W;

    logic [alc_pkg::CFG_W-1:0] word_bits_reg;

    // Input register
    logic             front_valid_reg;
    logic             front_ready;
    logic [PAD_W-1:0] first_reg;
    logic [PAD_W-1:0] second_reg;
    logic [PAD_W-1:0] sum_reg;
    logic [PAD_W-1:0] first_next;
    logic [PAD_W-1:0] second_next;
    logic [PAD_W-1:0] sum_next;

    // Scan pipeline links; index k feeds stage k
    logic                 v_pipe [NSTG+1];
    logic                 r_pipe [NSTG+1];
    logic [PAD_W-1:0]     a_pipe [NSTG+1];
    logic [PAD_W-1:0]     b_pipe [NSTG+1];
    logic [PAD_W-1:0]     c_pipe [NSTG+1];
    alc_pkg::scan_state_t s_pipe [NSTG+1];

    // Output register
    logic                      out_valid_reg;
    logic                      zero_reg;
    logic [alc_pkg::EXP_W-1:0] exponent_reg;
    logic                      negative_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_bits_reg <= alc_pkg::WORD_BITS_RESET;
        end
        else if (word_bits_we)
        begin
            word_bits_reg <= word_bits_wdata;
        end
    end

    // Drop mask bits outside the active word
    always_comb
    begin
        first_next  = '0;
        second_next = '0;
        sum_next    = '0;
        for (int i = 0; i < LIM; i++)
        begin
            if (7'(i) < {1'b0, word_bits_reg})
            begin
                first_next[i]  = mask_in.mask_first[i];
                second_next[i] = mask_in.mask_second[i];
                sum_next[i]    = mask_in.mask_sum[i];
            end
        end
    end

    assign front_ready   = !front_valid_reg || r_pipe[0];
    assign mask_in.ready = front_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (front_ready)
        begin
            front_valid_reg <= mask_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_ready && mask_in.valid)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            sum_reg    <= sum_next;
        end
    end

    assign v_pipe[0] = front_valid_reg;
    assign a_pipe[0] = first_reg;
    assign b_pipe[0] = second_reg;
    assign c_pipe[0] = sum_reg;
    assign s_pipe[0] = alc_pkg::SCAN_INIT;

    // Scan stages, eight columns each, most significant columns first
    for (genvar k = 0; k < NSTG; k++)
    begin : g_stage
        alc_scan_stage #(
            .PAD_W     (PAD_W),
            .STAGE_IDX (k)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (v_pipe[k]),
            .in_ready   (r_pipe[k]),
            .in_first   (a_pipe[k]),
            .in_second  (b_pipe[k]),
            .in_sum     (c_pipe[k]),
            .in_state   (s_pipe[k]),
            .out_valid  (v_pipe[k+1]),
            .out_ready  (r_pipe[k+1]),
            .out_first  (a_pipe[k+1]),
            .out_second (b_pipe[k+1]),
            .out_sum    (c_pipe[k+1]),
            .out_state  (s_pipe[k+1])
        );
    end

    // Output register: zero correlation reports exponent and sign as zero
    assign r_pipe[NSTG] = !out_valid_reg || corr_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (r_pipe[NSTG])
        begin
            out_valid_reg <= v_pipe[NSTG];
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_pipe[NSTG] && v_pipe[NSTG])
        begin
            zero_reg     <= s_pipe[NSTG].zero;
            exponent_reg <= s_pipe[NSTG].zero ? '0 : s_pipe[NSTG].exponent;
            negative_reg <= s_pipe[NSTG].neg & ~s_pipe[NSTG].zero;
        end
    end

    assign corr_out.valid         = out_valid_reg;
    assign corr_out.corr_zero     = zero_reg;
    assign corr_out.corr_exponent = exponent_reg;
    assign corr_out.corr_negative = negative_reg;

endmodule

`default_nettype wire

@@ rtl/alc_checker.sv @@
`default_nettype none

module alc_checker #(
    parameter int WORD_BITS = 32
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic                      corr_zero,
    input wire logic [alc_pkg::EXP_W-1:0] corr_exponent,
    input wire logic                      corr_negative
);

    localparam int IN_BITS = (WORD_BITS < alc_pkg::MASK_W) ? WORD_BITS : alc_pkg::MASK_W;

    // Input back-pressure only once the result side is stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("mask_in stalled while corr_out is free");

    // Zero correlation carries no exponent and no sign
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && corr_zero) |-> (corr_exponent == '0 && !corr_negative))
        else $error("zero correlation with non-zero exponent or sign");

    // Exponent cannot exceed the number of mask bits in use
    a_exp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(corr_exponent) <= 32'(IN_BITS)))
        else $error("correlation exponent beyond word size");

    // Held result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(corr_zero) && $stable(corr_exponent) &&
             $stable(corr_negative)))
        else $error("stalled result changed");

endmodule

bind add_linear_correlation_core alc_checker #(
    .WORD_BITS (WORD_BITS)
) u_alc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (mask_in.ready),
    .out_valid     (corr_out.valid),
    .out_ready     (corr_out.ready),
    .corr_zero     (corr_out.corr_zero),
    .corr_exponent (corr_out.corr_exponent),
    .corr_negative (corr_out.corr_negative)
);

`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_BITS = 32;
    // cycles without any beat before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // settle time after the last result: number of scan stages plus margin
    localparam int TAIL_CYCLES = (WORD_BITS + alc_pkg::COLS_PER_STAGE - 1) /
                                 alc_pkg::COLS_PER_STAGE + 10;
    localparam int MAX_REPORTS = 50;

    typedef enum logic [1:0] {OP_BEAT, OP_WB_WRITE, OP_DRAIN} op_kind_t;

    typedef struct {
        op_kind_t                   kind;
        logic [alc_pkg::MASK_W-1:0] first;
        logic [alc_pkg::MASK_W-1:0] second;
        logic [alc_pkg::MASK_W-1:0] sum;
        logic [alc_pkg::CFG_W-1:0]  wb;
    } pending_op_t;

    typedef struct packed {
        logic                      zero;
        logic [alc_pkg::EXP_W-1:0] exponent;
        logic                      negative;
    } corr_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      word_bits_we;
    logic [alc_pkg::CFG_W-1:0] word_bits_wdata;

    alc_in_if  in_ch ();
    alc_out_if out_ch ();

    add_linear_correlation_core #(
        .WORD_BITS(WORD_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .word_bits_we    (word_bits_we),
        .word_bits_wdata (word_bits_wdata),
        .mask_in         (in_ch),
        .corr_out        (out_ch)
    );

    pending_op_t               pending_ops[$];
    corr_t                     expected_corr[$];
    logic [alc_pkg::CFG_W-1:0] cur_word_bits;
    int                        mismatch_count = 0;
    int                        results_seen = 0;
    int                        send_gap;
    int                        stall_left;
    int                        idle_cycles = 0;
    int                        pace = 0;
    int                        pace_count = 0;

    always #2 clk = ~clk;

    // Correlation of the mask triple over the low word_bits columns, scanned from
    // the top column down with a one-bit carry state and a weight counter.
    function automatic corr_t addition_correlation(input logic [alc_pkg::MASK_W-1:0] fa,
                                                   input logic [alc_pkg::MASK_W-1:0] fb,
                                                   input logic [alc_pkg::MASK_W-1:0] fs,
                                                   input logic [alc_pkg::CFG_W-1:0] wb);
        corr_t                      res;
        int                         cols;
        int                         weight;
        bit                         carry;
        bit                         dead;
        logic [2:0]                 col;
        logic [alc_pkg::MASK_W-1:0] active;
        cols   = (int'(wb) > WORD_BITS) ? WORD_BITS : int'(wb);
        active = (cols >= alc_pkg::MASK_W) ? '1 :
                 ((alc_pkg::MASK_W'(1) << cols) - alc_pkg::MASK_W'(1));
        carry  = 1'b0;
        dead   = 1'b0;
        weight = 1;
        for (int i = cols - 1; i >= 0 && !dead; i--)
        begin
            col = {fs[i], fb[i], fa[i]};
            if (col == alc_pkg::COL_FULL)
            begin
                if (carry)
                    weight++;
                carry = ~carry;
            end
            else if (col == alc_pkg::COL_EMPTY)
            begin
                if (carry)
                    weight++;
            end
            else if (!carry)
                dead = 1'b1;
            else
            begin
                // a single set bit clears the carry, two set bits keep it
                weight++;
                if (^col)
                    carry = 1'b0;
            end
        end
        if (dead)
            res = '{zero: 1'b1, exponent: '0, negative: 1'b0};
        else
        begin
            res.zero     = 1'b0;
            res.exponent = (weight - 1 > int'(alc_pkg::EXP_MAX)) ? alc_pkg::EXP_MAX
                                                                 : alc_pkg::EXP_W'(weight - 1);
            res.negative = ^(((fa ^ fs) & (fb ^ fs)) & active);
        end
        return res;
    endfunction

    // Wait length for one beat; the pace decides between no idling, sparse
    // idling and heavy idling.
    function automatic int draw_wait();
        if (pace == 0)
            return 0;
        if (pace == 1)
            return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
        return int'($urandom_range(0, 17));
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s at result %0d: got %0d, want %0d",
                     field, results_seen, got, want);
    endtask

    // Re-draw the idling pace every so often so that quiet stretches and busy
    // stretches both occur on either side.
    always @(posedge clk)
    begin
        pace_count++;
        if (pace_count % 150 == 0)
            pace = $urandom_range(0, 2);
    end

    // Driver: feed beats, register writes and drain pauses from the pending queue.
    // Predict each beat at the edge where it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.mask_first  <= '0;
            in_ch.mask_second <= '0;
            in_ch.mask_sum    <= '0;
            word_bits_we      <= 1'b0;
            word_bits_wdata   <= '0;
            cur_word_bits     = alc_pkg::WORD_BITS_RESET;
            send_gap          = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_corr.push_back(addition_correlation(in_ch.mask_first,
                                                             in_ch.mask_second,
                                                             in_ch.mask_sum,
                                                             cur_word_bits));
            if (in_ch.valid && !in_ch.ready)
            begin
                // hold the beat until the block takes it
                word_bits_we <= 1'b0;
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid  <= 1'b0;
                word_bits_we <= 1'b0;
            end
            else if (pending_ops.size() == 0)
            begin
                in_ch.valid  <= 1'b0;
                word_bits_we <= 1'b0;
            end
            else
            begin
                case (pending_ops[0].kind)
                    OP_BEAT:
                    begin
                        in_ch.valid       <= 1'b1;
                        in_ch.mask_first  <= pending_ops[0].first;
                        in_ch.mask_second <= pending_ops[0].second;
                        in_ch.mask_sum    <= pending_ops[0].sum;
                        word_bits_we      <= 1'b0;
                        void'(pending_ops.pop_front());
                        send_gap = draw_wait();
                    end
                    OP_WB_WRITE:
                    begin
                        // write only once every beat in flight has come out
                        in_ch.valid <= 1'b0;
                        if (expected_corr.size() == 0)
                        begin
                            word_bits_we    <= 1'b1;
                            word_bits_wdata <= pending_ops[0].wb;
                            cur_word_bits   = pending_ops[0].wb;
                            void'(pending_ops.pop_front());
                        end
                        else
                            word_bits_we <= 1'b0;
                    end
                    default:
                    begin
                        // pause the sender until the pipeline has emptied
                        in_ch.valid  <= 1'b0;
                        word_bits_we <= 1'b0;
                        if (expected_corr.size() == 0)
                            void'(pending_ops.pop_front());
                    end
                endcase
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction, then stall
    // the receiver for a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left   = 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_corr.size() == 0)
                report_mismatch("unexpected result", 8'(out_ch.corr_zero), 8'd0);
            else
            begin
                corr_t want;
                want = expected_corr.pop_front();
                if (out_ch.corr_zero !== want.zero)
                    report_mismatch("corr_zero", 8'(out_ch.corr_zero), 8'(want.zero));
                if (out_ch.corr_exponent !== want.exponent)
                    report_mismatch("corr_exponent", 8'(out_ch.corr_exponent),
                                    8'(want.exponent));
                if (out_ch.corr_negative !== want.negative)
                    report_mismatch("corr_negative", 8'(out_ch.corr_negative),
                                    8'(want.negative));
            end
            stall_left = draw_wait();
            out_ch.ready <= (stall_left == 0);
        end
        else if (!out_ch.ready)
        begin
            if (stall_left <= 1)
            begin
                stall_left = 0;
                out_ch.ready <= 1'b1;
            end
            else
                stall_left--;
        end
    end

    // Watchdog: give up when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= HANG_LIMIT)
                begin
                    $display("tb NOT OK");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        pending_op_t                op;
        logic [alc_pkg::MASK_W-1:0] fa;
        logic [alc_pkg::MASK_W-1:0] fb;
        logic [alc_pkg::MASK_W-1:0] fs;
        logic [alc_pkg::MASK_W-1:0] corner[4];
        logic [2:0]                 col;
        logic [alc_pkg::CFG_W-1:0]  plan_wb;
        int                         phase_wb[5];
        int                         phase_len[5];
        int                         cols;
        int                         style;
        int                         len;
        bit                         carry;
        bit                         broken;

        rst_n = 1'b0;
        phase_wb  = '{1, 0, 63, 33, 32};
        phase_len = '{60, 20, 200, 100, 300};
        corner    = '{'0, '1, 32'h8000_0000, 32'h0000_0001};
        op.kind = OP_BEAT;
        op.wb   = '0;

        // Directed beats at the reset word size: empty and full masks, a lone
        // top column of every kind, and every kind following a full column.
        op.first = '0;  op.second = '0;  op.sum = '0;  pending_ops.push_back(op);
        op.first = '1;  op.second = '1;  op.sum = '1;  pending_ops.push_back(op);
        op.first = '1;  op.second = '0;  op.sum = '0;  pending_ops.push_back(op);
        op.first = '0;  op.second = '1;  op.sum = '1;  pending_ops.push_back(op);
        op.first = '0;  op.second = '0;  op.sum = 32'h1;  pending_ops.push_back(op);
        op.first = 32'h8000_0000;  op.second = 32'h8000_0000;  op.sum = 32'h8000_0000;
        pending_ops.push_back(op);
        for (int v = 0; v < 8; v++)
        begin
            col = 3'(v);
            op.first  = {col[0], 31'd0};
            op.second = {col[1], 31'd0};
            op.sum    = {col[2], 31'd0};
            pending_ops.push_back(op);
            op.first  = {1'b1, col[0], 30'd0};
            op.second = {1'b1, col[1], 30'd0};
            op.sum    = {1'b1, col[2], 30'd0};
            pending_ops.push_back(op);
        end

        // Random phases, each behind a register write; the first few pin the
        // word size to its extremes and to values past the word.
        for (int p = 0; p < 11; p++)
        begin
            if (p < 5)
            begin
                plan_wb = alc_pkg::CFG_W'(phase_wb[p]);
                len     = phase_len[p];
            end
            else
            begin
                plan_wb = ($urandom_range(0, 3) == 0) ?
                          alc_pkg::CFG_W'($urandom_range(0, 63)) :
                          alc_pkg::CFG_W'($urandom_range(1, 32));
                len     = 170;
            end
            op.kind = OP_WB_WRITE;
            op.wb   = plan_wb;
            pending_ops.push_back(op);
            op.kind = OP_BEAT;
            cols = (int'(plan_wb) > WORD_BITS) ? WORD_BITS : int'(plan_wb);
            for (int k = 0; k < len; k++)
            begin
                // drop the sender into a full drain now and then
                if (k == len / 2 && p % 3 == 2)
                begin
                    op.kind = OP_DRAIN;
                    pending_ops.push_back(op);
                    op.kind = OP_BEAT;
                end
                fa = $urandom;
                fb = $urandom;
                fs = $urandom;
                style = $urandom_range(0, 99);
                if (style < 70)
                begin
                    // well-formed scan: keep the carry state alive so the walk
                    // goes deep, with an occasional column that ends it
                    carry  = 1'b0;
                    broken = 1'b0;
                    for (int i = cols - 1; i >= 0 && !broken; i--)
                    begin
                        if (carry)
                            col = 3'($urandom_range(0, 7));
                        else if ($urandom_range(0, 39) == 0)
                        begin
                            col = 3'($urandom_range(1, 6));
                            broken = 1'b1;
                        end
                        else
                            col = $urandom_range(0, 1) ? alc_pkg::COL_FULL
                                                       : alc_pkg::COL_EMPTY;
                        if (col == alc_pkg::COL_FULL)
                            carry = ~carry;
                        else if (col != alc_pkg::COL_EMPTY && (^col))
                            carry = 1'b0;
                        fa[i] = col[0];
                        fb[i] = col[1];
                        fs[i] = col[2];
                    end
                end
                else if (style < 85)
                begin
                    // raw noise: leave the random masks as drawn
                end
                else if (style < 95)
                begin
                    fa = fa & $urandom & $urandom;
                    fb = fb & $urandom & $urandom;
                    fs = fs & $urandom & $urandom;
                end
                else
                begin
                    fa = corner[$urandom_range(0, 3)];
                    fb = corner[$urandom_range(0, 3)];
                    fs = corner[$urandom_range(0, 3)];
                end
                op.first  = fa;
                op.second = fb;
                op.sum    = fs;
                pending_ops.push_back(op);
            end
        end

        repeat (2) @(posedge clk);
        #1 rst_n = 1'b1;

        // Hold until every operation has gone out, then until every result is back.
        while (pending_ops.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (expected_corr.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
